// ===== sv/assert_macros.svh =====
// assertion macros shared by the encoder segment accumulator rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   `ASSERT_AT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

// ===== sv/edsa_pkg.sv =====
// types and constants for the encoder direction segment accumulator
// no dependencies; used by edsa_emitter and the top level
package edsa_pkg;

   localparam int COUNT_W = 16;
   localparam int SUM_W   = 16;

   typedef enum logic [2:0] {
      ACT_EDGE_CAP = 3'd0,
      ACT_SW_CAP   = 3'd1,
      ACT_EDGE_OVF = 3'd2,
      ACT_SW_OVF   = 3'd3,
      ACT_READ     = 3'd4,
      ACT_START    = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      DIR_INVALID  = 2'd0,
      DIR_FORWARD  = 2'd1,
      DIR_BACKWARD = 2'd2
   } dir_type;

   typedef enum logic [2:0] {
      ST_OKAY    = 3'd0,
      ST_BUF_OVF = 3'd1,
      ST_CAP_OVF = 3'd2,
      ST_SW_OVF  = 3'd3,
      ST_OTHER   = 3'd4
   } status_type;

   // read request handed from the tracker to the emitter
   typedef struct packed {
      logic       valid;
      logic       error;
      logic [1:0] elems;
      status_type status;
   } load_type;

endpackage

// ===== sv/edsa_emitter.sv =====
// read result emitter: holds a snapshot of the segment sums and sends one per transfer
// depends on edsa_pkg and assert_macros.svh
`include "assert_macros.svh"

module edsa_emitter
   import edsa_pkg::*;
#(
   parameter int SEGMENTS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  load_type           load,
   input  logic [SUM_W-1:0]   sums [SEGMENTS],
   output logic               idle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_slot_number,
   output logic signed [SUM_W-1:0] rsp_segment_sum,
   output logic [1:0]         rsp_element_count,
   output logic [2:0]         rsp_read_status,
   output logic               rsp_last_of_read
);

   localparam int CNT_W = $clog2(SEGMENTS + 1);

   logic [CNT_W-1:0] remaining_ff, remaining_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] snap_ff [SEGMENTS];
   logic [SUM_W-1:0] snap_in [SEGMENTS];
   logic [1:0]       elems_ff, elems_in;
   status_type       status_ff, status_in;
   logic             xfer;

   assign xfer = rsp_valid && rsp_ready;
   assign idle = (remaining_ff == '0) || ((remaining_ff == CNT_W'(1)) && rsp_ready);

   always_comb begin
      remaining_in = remaining_ff;
      idx_in       = idx_ff;
      elems_in     = elems_ff;
      status_in    = status_ff;
      for (int i = 0; i < SEGMENTS; i++) begin
         snap_in[i] = snap_ff[i];
      end
      if (load.valid) begin
         idx_in = '0;
         if (load.error) begin
            remaining_in = CNT_W'(1);
            snap_in[0]   = '0;
            elems_in     = 2'd0;
            status_in    = ST_OTHER;
         end else begin
            remaining_in = CNT_W'(SEGMENTS);
            elems_in     = load.elems;
            status_in    = load.status;
            for (int i = 0; i < SEGMENTS; i++) begin
               snap_in[i] = sums[i];
            end
         end
      end else if (xfer) begin
         remaining_in = remaining_ff - CNT_W'(1);
         idx_in       = idx_ff + CNT_W'(1);
         // shift line: the head always carries the next result
         for (int i = 0; i < SEGMENTS - 1; i++) begin
            snap_in[i] = snap_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         idx_ff       <= '0;
      end else begin
         remaining_ff <= remaining_in;
         idx_ff       <= idx_in;
      end
      elems_ff  <= elems_in;
      status_ff <= status_in;
      for (int i = 0; i < SEGMENTS; i++) begin
         snap_ff[i] <= snap_in[i];
      end
   end

   assign rsp_valid         = (remaining_ff != '0);
   assign rsp_slot_number   = idx_ff[0];
   assign rsp_segment_sum   = snap_ff[0];
   assign rsp_element_count = elems_ff;
   assign rsp_read_status   = status_ff;
   assign rsp_last_of_read  = (remaining_ff == CNT_W'(1));

   `ASSERT_AT(a_load_when_free, clock, reset, load.valid |-> idle, "read loaded while results pending")
   `ASSERT_NEXT(a_full_read_len, clock, reset, load.valid && !load.error, remaining_ff == CNT_W'(SEGMENTS), "read did not queue every slot")
   `ASSERT_NEXT(a_last_ends, clock, reset, xfer && rsp_last_of_read && !load.valid, !rsp_valid, "result after last of read")

endmodule

// ===== sv/encoder_direction_segment_accumulator.sv =====
// encoder direction segment accumulator, top level: capture tracking and segment sums
// depends on edsa_pkg, edsa_emitter and assert_macros.svh
//
// usage:
//   req channel (valid/ready) carries one action per transfer: direction-edge capture,
//   software capture, the two capture-overflow events, read and start.
//   captures add the wrapped 16-bit count delta into the open segment, signed by
//   direction; each direction change opens the next of SEGMENTS slots, and a change
//   with every slot used flags buffer overflow.
//   rsp channel (valid/ready) carries the results of a read: SEGMENTS transfers, one
//   per slot, last_of_read on the final one; a read with capacity below SEGMENTS gives
//   a single other-error transfer instead.
// timing:
//   every action updates the state at its transfer edge; a read's first result is
//   valid the cycle after its transfer.
//   non-read actions are taken every cycle, also while read results are waiting.
//   a read holds the result side until its last result has left, so a following read
//   is taken no sooner than when the last result of the previous one leaves; the
//   snapshot register of the emitter sets this limit.
// reset: clears the captures, direction, slots and status; no results pending.
// stall: while rsp_ready is low the results hold, non-read actions keep flowing and
//   a read waits at req_ready low.
`include "assert_macros.svh"

module encoder_direction_segment_accumulator
   import edsa_pkg::*;
#(
   parameter int SEGMENTS = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_action,
   input  logic [COUNT_W-1:0]      req_captured_count,
   input  logic                    req_direction_pin,
   input  logic [15:0]             req_capacity,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_slot_number,
   output logic signed [SUM_W-1:0] rsp_segment_sum,
   output logic [1:0]              rsp_element_count,
   output logic [2:0]              rsp_read_status,
   output logic                    rsp_last_of_read
);

   localparam int CNT_W = $clog2(SEGMENTS + 1);
   localparam int EXT_W = (CNT_W < 2) ? 2 : CNT_W;

   // tracking state
   logic [COUNT_W-1:0] prev_cap_ff, prev_cap_in;
   dir_type            prev_dir_ff, prev_dir_in;
   logic [CNT_W-1:0]   slot_ff, slot_in;
   logic [SUM_W-1:0]   sums_ff [SEGMENTS];
   logic [SUM_W-1:0]   sums_in [SEGMENTS];
   status_type         status_ff, status_in;

   action_type         action;
   dir_type            dir;
   logic               same_seg;
   logic               have_slot;
   logic [CNT_W-1:0]   slot_sel;
   logic [SUM_W-1:0]   cur_sum;
   logic [SUM_W-1:0]   new_sum;
   logic [COUNT_W-1:0] delta;
   logic [EXT_W-1:0]   slot_ext;
   logic               emit_idle;
   logic               req_xfer;
   load_type           load;

   assign action    = action_type'(req_action);
   assign req_ready = (action != ACT_READ) || emit_idle;
   assign req_xfer  = req_valid && req_ready;

   // pin sense is reversed between edge and software captures
   assign dir = (action == ACT_EDGE_CAP) ? (req_direction_pin ? DIR_FORWARD : DIR_BACKWARD)
                                         : (req_direction_pin ? DIR_BACKWARD : DIR_FORWARD);

   // first sample after clear stays in slot 0
   assign same_seg = (dir == prev_dir_ff) ||
                     ((slot_ff == '0) && (prev_dir_ff == DIR_INVALID));

   always_comb begin
      if (same_seg) begin
         slot_sel  = slot_ff;
         have_slot = (slot_ff < CNT_W'(SEGMENTS));
      end else begin
         // slot index saturates at SEGMENTS
         slot_sel  = (slot_ff < CNT_W'(SEGMENTS)) ? slot_ff + CNT_W'(1) : slot_ff;
         have_slot = (slot_sel < CNT_W'(SEGMENTS));
      end
   end

   assign delta = req_captured_count - prev_cap_ff;

   always_comb begin
      cur_sum = '0;
      for (int i = 0; i < SEGMENTS; i++) begin
         if (slot_sel == CNT_W'(i)) begin
            cur_sum = sums_ff[i];
         end
      end
   end

   assign new_sum = (dir == DIR_FORWARD) ? cur_sum + delta : cur_sum - delta;

   assign slot_ext = EXT_W'(slot_ff);

   always_comb begin
      prev_cap_in = prev_cap_ff;
      prev_dir_in = prev_dir_ff;
      slot_in     = slot_ff;
      status_in   = status_ff;
      for (int i = 0; i < SEGMENTS; i++) begin
         sums_in[i] = sums_ff[i];
      end
      load        = '0;
      load.status = status_ff;
      load.elems  = (slot_ff == '0) ? 2'd1 : slot_ext[1:0];
      if (req_xfer) begin
         case (action)
            ACT_EDGE_CAP, ACT_SW_CAP: begin
               slot_in     = slot_sel;
               prev_cap_in = req_captured_count;
               prev_dir_in = dir;
               if (!same_seg && !have_slot) begin
                  status_in = ST_BUF_OVF;
               end
               for (int i = 0; i < SEGMENTS; i++) begin
                  if (have_slot && (slot_sel == CNT_W'(i))) begin
                     sums_in[i] = new_sum;
                  end
               end
            end
            ACT_EDGE_OVF: begin
               status_in = ST_CAP_OVF;
            end
            ACT_SW_OVF: begin
               status_in = ST_SW_OVF;
            end
            ACT_READ: begin
               load.valid = 1'b1;
               status_in  = ST_OKAY;
               if (req_capacity < 16'(SEGMENTS)) begin
                  // too small a buffer: slots are kept
                  load.error = 1'b1;
               end else begin
                  slot_in = '0;
                  for (int i = 0; i < SEGMENTS; i++) begin
                     sums_in[i] = '0;
                  end
               end
            end
            ACT_START: begin
               prev_cap_in = '0;
               prev_dir_in = DIR_INVALID;
               slot_in     = '0;
               for (int i = 0; i < SEGMENTS; i++) begin
                  sums_in[i] = '0;
               end
            end
            default: begin
               // unused action codes do nothing
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cap_ff <= '0;
         prev_dir_ff <= DIR_INVALID;
         slot_ff     <= '0;
         status_ff   <= ST_OKAY;
         for (int i = 0; i < SEGMENTS; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         prev_cap_ff <= prev_cap_in;
         prev_dir_ff <= prev_dir_in;
         slot_ff     <= slot_in;
         status_ff   <= status_in;
         for (int i = 0; i < SEGMENTS; i++) begin
            sums_ff[i] <= sums_in[i];
         end
      end
   end

   // snapshot and result side
   edsa_emitter #(
      .SEGMENTS (SEGMENTS)
   ) u_emitter (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .sums              (sums_ff),
      .idle              (emit_idle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_slot_number   (rsp_slot_number),
      .rsp_segment_sum   (rsp_segment_sum),
      .rsp_element_count (rsp_element_count),
      .rsp_read_status   (rsp_read_status),
      .rsp_last_of_read  (rsp_last_of_read)
   );

   `ASSERT_AT(a_slot_range, clock, reset, slot_ff <= CNT_W'(SEGMENTS), "slot index beyond segment count")
   `ASSERT_NEXT(a_read_clears, clock, reset, req_xfer && (action == ACT_READ) && !load.error, (slot_ff == '0) && (status_ff == ST_OKAY), "read left slots or status")
   `ASSERT_NEXT(a_read_emits, clock, reset, req_xfer && (action == ACT_READ), rsp_valid, "read gave no result")

endmodule
